/* hdl/aabb_affine_transform_assert.svh */
// Assertion macros for the box transform RTL.
`ifndef AABB_AFFINE_TRANSFORM_ASSERT_SVH
`define AABB_AFFINE_TRANSFORM_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define AAT_ASSERT_IMPLIES(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: implication");

// Next-cycle implication, checked outside reset.
`define AAT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

// Next-cycle implication that also holds across reset.
`define AAT_ASSERT_RESET(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("assertion failed: reset behaviour");

`endif

/* hdl/aat_pkg.sv */
// Package: widths, beat types and lane helpers for the box transform.
`default_nettype none

package aat_pkg;

  localparam int LANE_BITS = 16;
  localparam int FRAC_BITS = 8;
  localparam int LANES     = 3;
  localparam int WORD_W    = 48;
  localparam int PACK_W    = LANES * LANE_BITS;
  localparam int EXT_W     = (PACK_W > WORD_W) ? PACK_W : WORD_W;
  localparam int PROD_W    = 2 * LANE_BITS;
  localparam int ORG_W     = LANE_BITS + FRAC_BITS;
  localparam int ACC_W     = ((PROD_W > ORG_W) ? PROD_W : ORG_W) + 2;

  typedef logic        [WORD_W-1:0]    word_t;
  typedef logic signed [LANE_BITS-1:0] lane_t;
  typedef logic signed [PROD_W-1:0]    prod_t;
  typedef logic signed [ACC_W-1:0]     acc_t;
  typedef logic        [1:0]           lane_idx_t;

  typedef struct packed {
    word_t basis_x_col;
    word_t basis_y_col;
    word_t basis_z_col;
    word_t origin_col;
    word_t box_lo;
    word_t box_hi;
  } in_beat_t;

  typedef struct packed {
    word_t out_lo;
    word_t out_hi;
    logic  clipped;
  } out_beat_t;

  // Per-stage advance strobes of the pipeline.
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
    logic s4;
  } adv_t;

  function automatic lane_t get_lane(word_t w, lane_idx_t k);
    logic [EXT_W-1:0] ext;
    ext = EXT_W'(w);
    return lane_t'(ext[32'(k) * LANE_BITS +: LANE_BITS]);
  endfunction

endpackage

`default_nettype wire

/* hdl/aat_lane.sv */
// One output lane: products, min/max split, accumulation, round and clamp.
`default_nettype none

module aat_lane (
  input  wire logic           clk,
  input  wire aat_pkg::adv_t  adv,
  input  wire aat_pkg::lane_t col    [3],
  input  wire aat_pkg::lane_t corner_lo [3],
  input  wire aat_pkg::lane_t corner_hi [3],
  input  wire aat_pkg::lane_t origin,
  output aat_pkg::lane_t      lo_q,
  output aat_pkg::lane_t      hi_q,
  output logic                clip_q
);
  import aat_pkg::*;

  localparam acc_t LANE_MAX = acc_t'((64'sd1 <<< (LANE_BITS - 1)) - 64'sd1);
  localparam acc_t LANE_MIN = -LANE_MAX - acc_t'(1);
  localparam acc_t HALF     = (FRAC_BITS > 0) ? acc_t'(64'sd1 <<< (FRAC_BITS - 1)) : '0;

  // stage 1
  prod_t prod_a [3];
  prod_t prod_b [3];
  lane_t org1;
  // stage 2
  acc_t  part_lo_a, part_lo_b, part_hi_a, part_hi_b;
  // stage 3
  acc_t  sum_lo, sum_hi;

  prod_t mn [3];
  prod_t mx [3];
  acc_t  org_ext;
  acc_t  rnd_lo, rnd_hi;
  lane_t sat_lo, sat_hi;
  logic  clip_lo, clip_hi;

  always_ff @(posedge clk) begin
    if (adv.s1) begin
      for (int j = 0; j < 3; j++) begin
        prod_a[j] <= prod_t'(col[j]) * prod_t'(corner_lo[j]);
        prod_b[j] <= prod_t'(col[j]) * prod_t'(corner_hi[j]);
      end
      org1 <= origin;
    end
  end

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      if (prod_a[j] < prod_b[j]) begin
        mn[j] = prod_a[j];
        mx[j] = prod_b[j];
      end else begin
        mn[j] = prod_b[j];
        mx[j] = prod_a[j];
      end
    end
    org_ext = acc_t'(org1) <<< FRAC_BITS;
  end

  always_ff @(posedge clk) begin
    if (adv.s2) begin
      part_lo_a <= org_ext + acc_t'(mn[0]);
      part_lo_b <= acc_t'(mn[1]) + acc_t'(mn[2]);
      part_hi_a <= org_ext + acc_t'(mx[0]);
      part_hi_b <= acc_t'(mx[1]) + acc_t'(mx[2]);
    end
  end

  always_ff @(posedge clk) begin
    if (adv.s3) begin
      sum_lo <= part_lo_a + part_lo_b;
      sum_hi <= part_hi_a + part_hi_b;
    end
  end

  // Round half up, then clamp to the lane range.
  always_comb begin
    rnd_lo = (sum_lo + HALF) >>> FRAC_BITS;
    rnd_hi = (sum_hi + HALF) >>> FRAC_BITS;
    clip_lo = 1'b1;
    clip_hi = 1'b1;
    if (rnd_lo > LANE_MAX) begin
      sat_lo = LANE_MAX[LANE_BITS-1:0];
    end else if (rnd_lo < LANE_MIN) begin
      sat_lo = LANE_MIN[LANE_BITS-1:0];
    end else begin
      sat_lo  = rnd_lo[LANE_BITS-1:0];
      clip_lo = 1'b0;
    end
    if (rnd_hi > LANE_MAX) begin
      sat_hi = LANE_MAX[LANE_BITS-1:0];
    end else if (rnd_hi < LANE_MIN) begin
      sat_hi = LANE_MIN[LANE_BITS-1:0];
    end else begin
      sat_hi  = rnd_hi[LANE_BITS-1:0];
      clip_hi = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv.s4) begin
      lo_q   <= sat_lo;
      hi_q   <= sat_hi;
      clip_q <= clip_lo | clip_hi;
    end
  end

endmodule

`default_nettype wire

/* hdl/aabb_affine_transform.sv */
// Top level: streaming affine transform of axis-aligned boxes, four-stage pipeline.
// A result beat is offered after its item passes the multiply, partial-sum, final-sum and output registers.
// Throughput: one beat per cycle while result_ready holds; each stage holds one item and moves when the next frees up.
// Stages: multiply, min/max with partial sums, final sum, round and clamp into the output.
// Reset (synchronous, active high) clears only the stage valid bits; data registers keep junk.
// No configuration and no state carry between items.
`default_nettype none

`include "aabb_affine_transform_assert.svh"

module aabb_affine_transform (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              item_valid,
  output logic                   item_ready,
  input  wire aat_pkg::in_beat_t item,
  output logic                   result_valid,
  input  wire logic              result_ready,
  output aat_pkg::out_beat_t     result
);
  import aat_pkg::*;

  // One valid bit per stage; bit 3 is the output register.
  logic [3:0] stage_valid;
  adv_t       adv;

  lane_t col_lane   [LANES][3];
  lane_t lo_lane    [LANES][3];
  lane_t hi_lane    [LANES][3];
  lane_t org_lane   [LANES];
  lane_t res_lo     [LANES];
  lane_t res_hi     [LANES];
  logic  [LANES-1:0] res_clip;
  logic  [PACK_W-1:0] pack_lo, pack_hi;

  // A stage advances when it is empty or when the stage after it advances.
  // The chain ends at the consumer's ready, so a stall freezes everything
  // from the back and nothing is dropped or repeated.
  always_comb begin
    adv.s4     = !stage_valid[3] || result_ready;
    adv.s3     = !stage_valid[2] || adv.s4;
    adv.s2     = !stage_valid[1] || adv.s3;
    adv.s1     = !stage_valid[0] || adv.s2;
    item_ready = adv.s1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= '0;
    end else begin
      if (adv.s1) stage_valid[0] <= item_valid;
      if (adv.s2) stage_valid[1] <= stage_valid[0];
      if (adv.s3) stage_valid[2] <= stage_valid[1];
      if (adv.s4) stage_valid[3] <= stage_valid[2];
    end
  end

  // Unpack the item words into lanes; lane i of every column feeds output lane i.
  for (genvar i = 0; i < LANES; i++) begin : g_unpack
    for (genvar j = 0; j < 3; j++) begin : g_axis
      assign lo_lane[i][j] = get_lane(item.box_lo, lane_idx_t'(j));
      assign hi_lane[i][j] = get_lane(item.box_hi, lane_idx_t'(j));
    end
    assign col_lane[i][0] = get_lane(item.basis_x_col, lane_idx_t'(i));
    assign col_lane[i][1] = get_lane(item.basis_y_col, lane_idx_t'(i));
    assign col_lane[i][2] = get_lane(item.basis_z_col, lane_idx_t'(i));
    assign org_lane[i]    = get_lane(item.origin_col, lane_idx_t'(i));

    aat_lane u_lane (
      .clk       (clk),
      .adv       (adv),
      .col       (col_lane[i]),
      .corner_lo (lo_lane[i]),
      .corner_hi (hi_lane[i]),
      .origin    (org_lane[i]),
      .lo_q      (res_lo[i]),
      .hi_q      (res_hi[i]),
      .clip_q    (res_clip[i])
    );

    assign pack_lo[i*LANE_BITS +: LANE_BITS] = res_lo[i];
    assign pack_hi[i*LANE_BITS +: LANE_BITS] = res_hi[i];
  end

  // Drop lane bits beyond the 48-bit word; pad with zeros where the lanes fall short.
  assign result_valid   = stage_valid[3];
  assign result.out_lo  = WORD_W'(pack_lo);
  assign result.out_hi  = WORD_W'(pack_hi);
  assign result.clipped = |res_clip;

  // Checks on the pipeline and the arithmetic.
  `AAT_ASSERT_RESET(a_reset_empty, rst, stage_valid == 4'b0000)
  `AAT_ASSERT_NEXT(a_accept_enters, item_valid && item_ready, stage_valid[0])
  `AAT_ASSERT_NEXT(a_tail_loads, stage_valid[2] && adv.s4, result_valid)

  for (genvar k = 0; k < LANES; k++) begin : g_chk
    // Min products never exceed max products, and rounding and clamping keep order.
    `AAT_ASSERT_IMPLIES(a_lo_le_hi, result_valid, res_lo[k] <= res_hi[k])
  end

endmodule

`default_nettype wire

/* bench/box_transform_checker.sv */
// Box transform checker: watches both beat channels, predicts each box and compares the results.
`timescale 1ns / 1ps

module box_transform_checker
  import aat_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      item_valid,
  input  logic      item_ready,
  input  in_beat_t  item,
  input  logic      result_valid,
  input  logic      result_ready,
  input  out_beat_t result,
  output int        fail_count,
  output int        pending
);

  localparam longint HALF_LSB = (longint'(1) << FRAC_BITS) / 2;
  localparam longint LANE_MAX = (longint'(1) << (LANE_BITS - 1)) - 1;
  localparam longint LANE_MIN = -LANE_MAX - 1;

  out_beat_t due_boxes[$];

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  function automatic longint lane_value(word_t w, int k);
    lane_t v;
    v = w[k * LANE_BITS +: LANE_BITS];
    return longint'(v);
  endfunction

  // Round half up to the lane's fraction, then clamp and flag any clamp.
  function automatic lane_t settle_lane(longint acc, inout logic clip);
    longint r;
    r = (acc + HALF_LSB) >>> FRAC_BITS;
    if (r > LANE_MAX) begin
      clip = 1'b1;
      r    = LANE_MAX;
    end else if (r < LANE_MIN) begin
      clip = 1'b1;
      r    = LANE_MIN;
    end
    return lane_t'(r);
  endfunction

  function automatic out_beat_t transform_box(in_beat_t b);
    word_t     cols [3];
    longint    sum_lo;
    longint    sum_hi;
    longint    c;
    longint    p_a;
    longint    p_b;
    logic      clip;
    out_beat_t r;
    cols[0] = b.basis_x_col;
    cols[1] = b.basis_y_col;
    cols[2] = b.basis_z_col;
    r       = '0;
    clip    = 1'b0;
    for (int i = 0; i < LANES; i++) begin
      sum_lo = lane_value(b.origin_col, i) * (longint'(1) << FRAC_BITS);
      sum_hi = sum_lo;
      for (int j = 0; j < LANES; j++) begin
        c   = lane_value(cols[j], i);
        p_a = c * lane_value(b.box_lo, j);
        p_b = c * lane_value(b.box_hi, j);
        if (p_a < p_b) begin
          sum_lo += p_a;
          sum_hi += p_b;
        end else begin
          sum_lo += p_b;
          sum_hi += p_a;
        end
      end
      r.out_lo[i * LANE_BITS +: LANE_BITS] = settle_lane(sum_lo, clip);
      r.out_hi[i * LANE_BITS +: LANE_BITS] = settle_lane(sum_hi, clip);
    end
    r.clipped = clip;
    return r;
  endfunction

  always @(posedge clk) begin
    out_beat_t want;
    if (!rst) begin
      // Retire first, so a beat can never be matched against its own item.
      if (result_valid && result_ready) begin
        if (due_boxes.size() == 0) begin
          $error("result beat with no box due: out_lo %h out_hi %h clipped %b",
                 result.out_lo, result.out_hi, result.clipped);
          fail_count++;
        end else begin
          want = due_boxes.pop_front();
          if (result.out_lo !== want.out_lo) begin
            $error("out_lo: expected %h, got %h", want.out_lo, result.out_lo);
            fail_count++;
          end
          if (result.out_hi !== want.out_hi) begin
            $error("out_hi: expected %h, got %h", want.out_hi, result.out_hi);
            fail_count++;
          end
          if (result.clipped !== want.clipped) begin
            $error("clipped: expected %b, got %b", want.clipped, result.clipped);
            fail_count++;
          end
        end
      end
      if (item_valid && item_ready) due_boxes.push_back(transform_box(item));
    end
    pending = due_boxes.size();
  end

endmodule

/* bench/tb_top.sv */
// Testbench top for the box transform: drives box beats, paces the receiver, gives the verdict.
`timescale 1ns / 1ps

module tb_top;
  import aat_pkg::*;

  // Stimulus sizing.
  localparam int RANDOM_ITEMS = 750;
  localparam int CALM_ITEMS   = 120;  // final stretch with no idling on either side
  localparam int HOLD_AT      = 200;  // boxes sent before the long receiver hold-off
  localparam int LONG_HOLD    = 60;   // far longer than the four-stage pipe can absorb
  localparam int DRAIN_CYCLES = 8;    // slack for stray beats after the last box is due

  // The slowest correct stretch without any beat is the long hold-off plus a
  // short burst and the pipe latency, well under this limit.
  localparam int WATCHDOG_LIMIT = 2000;

  // Handy lane values in Q8.8.
  localparam int ONE  = 1 << FRAC_BITS;
  localparam int MAXL = (1 << (LANE_BITS - 1)) - 1;
  localparam int MINL = -(1 << (LANE_BITS - 1));

  logic      clk;
  logic      rst;
  logic      item_valid;
  logic      item_ready;
  in_beat_t  item;
  logic      result_valid;
  logic      result_ready;
  out_beat_t result;

  int   fail_count;
  int   pending;
  int   boxes_sent;
  int   idle_cycles;
  logic calm;
  logic long_hold_done;

  aabb_affine_transform dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  box_transform_checker checker_i (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result),
    .fail_count   (fail_count),
    .pending      (pending)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Pack three signed lane values into one word, x lowest.
  function automatic word_t pack_lanes(int x, int y, int z);
    word_t w;
    w = '0;
    w[0 +: LANE_BITS]             = x[LANE_BITS-1:0];
    w[LANE_BITS +: LANE_BITS]     = y[LANE_BITS-1:0];
    w[2 * LANE_BITS +: LANE_BITS] = z[LANE_BITS-1:0];
    return w;
  endfunction

  function automatic word_t splat(int v);
    return pack_lanes(v, v, v);
  endfunction

  function automatic int rand_lane(int lim);
    return int'($urandom_range(0, 2 * lim)) - lim;
  endfunction

  // Lane values near the corners of the arithmetic: saturation, rounding, unit scale.
  function automatic int extreme_lane();
    case ($urandom_range(0, 9))
      0:       return 0;
      1:       return 1;
      2:       return -1;
      3:       return ONE;
      4:       return -ONE;
      5:       return MAXL;
      6:       return MINL;
      7:       return ONE / 2;
      8:       return -ONE / 2;
      default: return rand_lane(MAXL);
    endcase
  endfunction

  function automatic word_t extreme_word();
    return pack_lanes(extreme_lane(), extreme_lane(), extreme_lane());
  endfunction

  function automatic word_t raw_word();
    return word_t'({$urandom, $urandom});
  endfunction

  // Offer one box beat; hold valid and payload until it is taken.
  task automatic send_box(word_t bx, word_t by, word_t bz, word_t org, word_t lo, word_t hi);
    in_beat_t b;
    b.basis_x_col = bx;
    b.basis_y_col = by;
    b.basis_z_col = bz;
    b.origin_col  = org;
    b.box_lo      = lo;
    b.box_hi      = hi;
    @(negedge clk);
    if (!calm && $urandom_range(0, 3) == 0) begin
      item_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    item_valid <= 1'b1;
    item       <= b;
    @(posedge clk);
    while (!item_ready) @(posedge clk);
    boxes_sent++;
  endtask

  // Mostly well-ordered boxes under modest matrices, the rest raw noise and corner values.
  task automatic send_random_box();
    int    mode;
    int    a;
    int    c;
    int    lo_l [3];
    int    hi_l [3];
    word_t cols [3];
    mode = $urandom_range(0, 9);
    if (mode < 6) begin
      for (int k = 0; k < 3; k++) begin
        a       = rand_lane(4096);
        c       = rand_lane(4096);
        lo_l[k] = (a < c) ? a : c;
        hi_l[k] = (a < c) ? c : a;
        cols[k] = pack_lanes(rand_lane(2 * ONE), rand_lane(2 * ONE), rand_lane(2 * ONE));
      end
      send_box(cols[0], cols[1], cols[2],
               pack_lanes(rand_lane(8192), rand_lane(8192), rand_lane(8192)),
               pack_lanes(lo_l[0], lo_l[1], lo_l[2]),
               pack_lanes(hi_l[0], hi_l[1], hi_l[2]));
    end else if (mode < 8) begin
      send_box(raw_word(), raw_word(), raw_word(), raw_word(), raw_word(), raw_word());
    end else begin
      send_box(extreme_word(), extreme_word(), extreme_word(),
               extreme_word(), extreme_word(), extreme_word());
    end
  endtask

  // Stimulus: reset, directed corner cases, then random boxes.
  initial begin
    word_t lo_w;
    rst        = 1'b1;
    item_valid = 1'b0;
    item       = '0;
    calm       = 1'b0;
    boxes_sent = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // All zero.
    send_box('0, '0, '0, '0, '0, '0);
    // Identity matrix with a translation, then the same box with its corners swapped.
    send_box(pack_lanes(ONE, 0, 0), pack_lanes(0, ONE, 0), pack_lanes(0, 0, ONE),
             pack_lanes(10, -20, 30), pack_lanes(-384, 128, 640), pack_lanes(512, 1000, -100));
    send_box(pack_lanes(ONE, 0, 0), pack_lanes(0, ONE, 0), pack_lanes(0, 0, ONE),
             pack_lanes(10, -20, 30), pack_lanes(512, 1000, -100), pack_lanes(-384, 128, 640));
    // Mirror the box through a negative unit matrix.
    send_box(pack_lanes(-ONE, 0, 0), pack_lanes(0, -ONE, 0), pack_lanes(0, 0, -ONE),
             '0, pack_lanes(-300, 40, 5), pack_lanes(700, 90, 6000));
    // Every lane at its positive and its negative extreme.
    send_box(splat(MAXL), splat(MAXL), splat(MAXL), splat(MAXL), splat(MAXL), splat(MAXL));
    send_box(splat(MINL), splat(MINL), splat(MINL), splat(MINL), splat(MINL), splat(MINL));
    // Widest box under the largest matrix: clamp both ends.
    send_box(splat(MAXL), splat(MAXL), splat(MAXL), '0, splat(MINL), splat(MAXL));
    // Zero matrix: the output is the origin alone, at either extreme.
    send_box('0, '0, '0, splat(MAXL), splat(MINL), splat(MAXL));
    send_box('0, '0, '0, splat(MINL), splat(MAXL), splat(MINL));
    // Exact half rounds up; a negative half rounds towards zero; just past it goes down.
    send_box(pack_lanes(1, 0, 0), '0, '0, '0, splat(ONE / 2), splat(ONE / 2));
    send_box(pack_lanes(0, -1, 0), '0, '0, '0, splat(ONE / 2), splat(ONE / 2));
    send_box(pack_lanes(0, 0, -1), '0, '0, '0, splat(ONE / 2 + 1), splat(ONE / 2 + 1));
    // Top of the lane: half an LSB over clamps, half under does not.
    send_box(splat(1), '0, '0, splat(MAXL), splat(ONE / 2), splat(ONE / 2));
    send_box(splat(-1), '0, '0, splat(MAXL), splat(ONE / 2), splat(ONE / 2));
    // Bottom of the lane: just past the minimum clamps, the minimum itself does not.
    send_box(splat(-1), '0, '0, splat(MINL), splat(ONE / 2 + 1), splat(ONE / 2 + 1));
    send_box(splat(-1), '0, '0, splat(MINL), splat(ONE / 2), splat(ONE / 2));
    // All ones, then alternating bit patterns.
    send_box(splat(-1), splat(-1), splat(-1), splat(-1), splat(-1), splat(-1));
    send_box(48'hAAAA_AAAA_AAAA, 48'h5555_5555_5555, 48'hAAAA_AAAA_AAAA,
             48'h5555_5555_5555, 48'hAAAA_AAAA_AAAA, 48'h5555_5555_5555);
    send_box(48'h5555_5555_5555, 48'hAAAA_AAAA_AAAA, 48'h5555_5555_5555,
             48'hAAAA_AAAA_AAAA, 48'h5555_5555_5555, 48'hAAAA_AAAA_AAAA);
    // Degenerate box: both corners the same point.
    lo_w = pack_lanes(rand_lane(4096), rand_lane(4096), rand_lane(4096));
    send_box(raw_word(), raw_word(), raw_word(), raw_word(), lo_w, lo_w);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == RANDOM_ITEMS - CALM_ITEMS) calm = 1'b1;
      send_random_box();
    end
    @(negedge clk);
    item_valid <= 1'b0;

    // Drain: wait for every box due, then wait out DRAIN_CYCLES for stray beats.
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("aabb_affine_transform regression: pass");
    end else begin
      $display("aabb_affine_transform regression: fail");
    end
    $finish;
  end

  // Receiver: random short stalls, plus one long hold-off so the pipe fills and
  // backs up into the input while the sender keeps offering.
  initial begin
    result_ready   = 1'b0;
    long_hold_done = 1'b0;
    wait (!rst);
    @(negedge clk);
    forever begin
      if (!long_hold_done && boxes_sent >= HOLD_AT) begin
        result_ready <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
        long_hold_done = 1'b1;
      end else if (!calm && $urandom_range(0, 4) == 0) begin
        result_ready <= 1'b0;
        repeat ($urandom_range(1, 4)) @(negedge clk);
      end
      result_ready <= 1'b1;
      @(negedge clk);
    end
  end

  // Watchdog: count cycles with no beat on either channel.
  always @(posedge clk) begin
    if (rst || (item_valid && item_ready) || (result_valid && result_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("aabb_affine_transform regression: fail");
      $finish;
    end
  end

endmodule

/* files.f */
+incdir+hdl
hdl/aat_pkg.sv
hdl/aat_lane.sv
hdl/aabb_affine_transform.sv
bench/box_transform_checker.sv
bench/tb_top.sv
